### design/nqb_pkg.sv
// nqb_pkg: shared types and constants for the n-queens backtracking search
// used by nqb_board and n_queens_backtrack_search; no dependencies
`default_nettype none

package nqb_pkg;

  localparam int DEF_MAX_N      = 8;
  localparam int CFG_W          = 4;
  localparam int PACK_COLS      = 8;
  localparam int PACK_BITS      = 3;
  localparam int OUT_W          = PACK_COLS * PACK_BITS;
  localparam logic [CFG_W-1:0] BOARD_SIZE_RST = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESUME,
    ST_SCAN,
    ST_DONE
  } nqb_state_t;

  // command from the sequencer to the board unit
  typedef struct packed {
    logic clear;
    logic toggle;
  } nqb_brd_cmd_t;

endpackage

`default_nettype wire

### design/nqb_board.sv
// nqb_board: busy masks for rows and both diagonal families, with one shared
// free test and toggle port at (col, row); depends on nqb_pkg
`default_nettype none

module nqb_board import nqb_pkg::*; #(
  parameter int MAX_N = DEF_MAX_N
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire nqb_brd_cmd_t                             cmd,
  input  wire logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] col,
  input  wire logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] row,
  input  wire logic [$clog2(MAX_N + 1)-1:0]             n,
  output logic                                          is_free
);

  localparam int RW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int DIAGS = 2 * MAX_N - 1;
  localparam int DW    = (DIAGS > 1) ? $clog2(DIAGS) : 1;

  logic [MAX_N-1:0] row_busy;
  logic [DIAGS-1:0] sum_diag_busy;
  logic [DIAGS-1:0] diff_diag_busy;
  logic [DW-1:0]    sum_idx;
  logic [DW-1:0]    diff_idx;

  assign sum_idx  = DW'(row) + DW'(col);
  // n-1+col-row never goes negative for col,row < n
  assign diff_idx = DW'(n) - DW'(1) + DW'(col) - DW'(row);

  assign is_free = !row_busy[row] && !sum_diag_busy[sum_idx] && !diff_diag_busy[diff_idx];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      row_busy       <= '0;
      sum_diag_busy  <= '0;
      diff_diag_busy <= '0;
    end else if (cmd.toggle) begin
      row_busy[row]            <= ~row_busy[row];
      sum_diag_busy[sum_idx]   <= ~sum_diag_busy[sum_idx];
      diff_diag_busy[diff_idx] <= ~diff_diag_busy[diff_idx];
    end
  end

endmodule

`default_nettype wire

### design/n_queens_backtrack_search.sv
// n_queens_backtrack_search: top level, request handshake, search sequencer,
// stack of chosen rows and result register; depends on nqb_pkg, nqb_board
`default_nettype none

// Each item asks for the next n-queens solution on a board of board_size
// (0 reads as 1, above MAX_N saturates): restart=1 begins a new search,
// restart=0 resumes after the last solution. The result carries found and
// the queen row of each column, 3 bits per column, zero when the search is
// exhausted. The result is loaded after the search steps that follow the
// accepted item (one candidate test or one backtrack per cycle through the
// single free-test port of the board unit); a resume first passes through
// the RESUME state, and a continue on an exhausted search goes straight to
// the result. in_ready rises together with out_valid, later while the output
// register still holds an unread result. Writing board_size clears the
// board and needs a restart.

module n_queens_backtrack_search import nqb_pkg::*; #(
  parameter int MAX_N = DEF_MAX_N
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] board_size,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             restart,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  found,
  output logic [OUT_W-1:0]      queen_rows
);

  localparam int RW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CW = $clog2(MAX_N + 1);
  localparam int PC = (MAX_N < PACK_COLS) ? MAX_N : PACK_COLS;

  nqb_state_t state, state_next;

  logic [CFG_W-1:0] size_reg;
  logic [CW-1:0]    n;
  logic [CW-1:0]    depth, depth_next;
  logic [CW-1:0]    cand, cand_next;
  logic             exhausted, exhausted_next;
  logic             found_r, found_next;
  logic [RW-1:0]    stack [MAX_N];
  logic             stack_we;
  logic [RW-1:0]    top_row;
  logic [CW-1:0]    depth_m1;
  logic [RW-1:0]    brd_col, brd_row;
  logic             brd_free;
  logic             backtrack;
  logic             out_load;
  logic [OUT_W-1:0] packed_rows;
  nqb_brd_cmd_t     brd_cmd;

  always_comb begin
    if (size_reg == '0) begin
      n = CW'(1);
    end else if (int'(size_reg) > MAX_N) begin
      n = CW'(MAX_N);
    end else begin
      n = CW'(size_reg);
    end
  end

  assign depth_m1 = depth - CW'(1);
  assign top_row  = stack[depth_m1[RW-1:0]];
  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // backtrack: pop the top column, in RESUME or when candidates ran out
  assign backtrack = (state == ST_RESUME) ||
                     ((state == ST_SCAN) && (depth < n) && (cand >= n) && (depth != '0));

  always_comb begin
    if (backtrack) begin
      brd_col = depth_m1[RW-1:0];
      brd_row = top_row;
    end else begin
      brd_col = depth[RW-1:0];
      brd_row = cand[RW-1:0];
    end
  end

  nqb_board #(.MAX_N(MAX_N)) u_board (
    .clk     (clk),
    .rst     (rst),
    .cmd     (brd_cmd),
    .col     (brd_col),
    .row     (brd_row),
    .n       (n),
    .is_free (brd_free)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (restart) begin
            state_next = ST_SCAN;
          end else if (exhausted) begin
            state_next = ST_DONE;
          end else if (depth != '0 && depth <= n) begin
            state_next = ST_RESUME;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_RESUME: state_next = ST_SCAN;
      ST_SCAN: begin
        if (depth >= n || (cand >= n && depth == '0)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    depth_next     = depth;
    cand_next      = cand;
    exhausted_next = exhausted;
    found_next     = found_r;
    stack_we       = 1'b0;
    brd_cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (restart) begin
            brd_cmd.clear  = 1'b1;
            exhausted_next = 1'b0;
            depth_next     = '0;
            cand_next      = '0;
          end else if (exhausted) begin
            found_next = 1'b0;
          end else begin
            cand_next = '0;
          end
        end
      end
      ST_RESUME: begin
        brd_cmd.toggle = 1'b1;
        depth_next     = depth_m1;
        cand_next      = CW'(top_row) + CW'(1);
      end
      ST_SCAN: begin
        if (depth >= n) begin
          found_next = 1'b1;
        end else if (cand >= n) begin
          if (depth == '0) begin
            brd_cmd.clear  = 1'b1;
            exhausted_next = 1'b1;
            found_next     = 1'b0;
          end else begin
            brd_cmd.toggle = 1'b1;
            depth_next     = depth_m1;
            cand_next      = CW'(top_row) + CW'(1);
          end
        end else if (brd_free) begin
          brd_cmd.toggle = 1'b1;
          stack_we       = 1'b1;
          depth_next     = depth + CW'(1);
          cand_next      = '0;
        end else begin
          cand_next = cand + CW'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
    if (cfg_we) begin
      brd_cmd.clear  = 1'b1;
      exhausted_next = 1'b1;
      depth_next     = '0;
    end
  end

  always_comb begin
    packed_rows = '0;
    for (int c = 0; c < PC; c++) begin
      if (CW'(c) < n) begin
        packed_rows[c*PACK_BITS +: PACK_BITS] = PACK_BITS'(stack[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      size_reg  <= BOARD_SIZE_RST;
      depth     <= '0;
      exhausted <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      depth     <= depth_next;
      exhausted <= exhausted_next;
      if (cfg_we) begin
        size_reg <= board_size;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cand    <= cand_next;
    found_r <= found_next;
    if (stack_we) begin
      stack[depth[RW-1:0]] <= cand[RW-1:0];
    end
    if (out_load) begin
      found      <= found_r;
      queen_rows <= found_r ? packed_rows : '0;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= n)
    else $error("search depth beyond board size");

  a_cand_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cand <= n))
    else $error("candidate row beyond board size");

  a_scan_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_RESUME) |-> !exhausted)
    else $error("search running on an exhausted board");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (queen_rows == '0))
    else $error("not-found item carries queen rows");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("accepted item left sequencer idle");

endmodule

`default_nettype wire
